[rtl/core/websocket_frame_receiver_macros.svh]
// Assertion macros shared by the frame receiver RTL.
// Uses the clk and rst_n names of the including module.
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wsfr_pkg.sv]
// Shared types and constants of the WebSocket frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsfr_pkg;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CTRL  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_PONG  = 2'd1;
  localparam logic [1:0] REPLY_ECHO  = 2'd2;
  localparam logic [1:0] REPLY_CLOSE = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERSIZE = 2'd1;
  localparam logic [1:0] ERR_FRAGMENT = 2'd2;
  localparam logic [1:0] ERR_CONTROL  = 2'd3;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'h7E;
  localparam logic [6:0] LEN_EXT64 = 7'h7F;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [1:0] kind;
    logic [3:0] opcode;
    logic [1:0] reply;
    logic [1:0] error_code;
    logic       last;
  } wsfr_result_t;

  typedef struct packed {
    logic         has_res;
    wsfr_result_t res;
  } wsfr_status_t;

endpackage

`default_nettype wire

[rtl/core/wsfr_frame_fsm.sv]
// Frame parser: header, extended length, mask key and payload state.
// Depends on wsfr_pkg and websocket_frame_receiver_macros.svh.
`default_nettype none
`include "websocket_frame_receiver_macros.svh"

module wsfr_frame_fsm (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_data,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 fire,
  output wsfr_pkg::wsfr_status_t    status
);
  import wsfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      frame_head_r, frame_head_nxt;
  logic            mask_present_r, mask_present_nxt;
  logic [2:0]      len_left_r, len_left_nxt;
  logic [63:0]     payload_left_r, payload_left_nxt;
  logic [3:0][7:0] mask_key_r, mask_key_nxt;
  logic [1:0]      mask_index_r, mask_index_nxt;
  logic            fragment_open_r, fragment_open_nxt;
  logic [3:0]      message_opcode_r, message_opcode_nxt;
  logic [31:0]     max_payload_r;
  wsfr_result_t    res;
  logic            has_res;

  always_comb begin
    logic [3:0] op;
    logic       fin;
    logic       len_done;
    logic       hdr_done;
    logic       final_byte;
    logic [7:0] key_byte;
    logic [7:0] data_byte;

    op                 = frame_head_r[3:0];
    fin                = frame_head_r[7];
    len_done           = 1'b0;
    hdr_done           = 1'b0;
    final_byte         = (payload_left_r == 64'd1);
    key_byte           = mask_present_r ? mask_key_r[2'd3 - mask_index_r] : 8'd0;
    data_byte          = rx_byte ^ key_byte;
    phase_nxt          = phase_r;
    frame_head_nxt     = frame_head_r;
    mask_present_nxt   = mask_present_r;
    len_left_nxt       = len_left_r;
    payload_left_nxt   = payload_left_r;
    mask_key_nxt       = mask_key_r;
    mask_index_nxt     = mask_index_r;
    fragment_open_nxt  = fragment_open_r;
    message_opcode_nxt = message_opcode_r;
    res                = '0;
    has_res            = 1'b0;

    case (phase_r)
      PH_HEAD0: begin
        frame_head_nxt = rx_byte;
        phase_nxt      = PH_HEAD1;
      end
      PH_HEAD1: begin
        mask_present_nxt = rx_byte[7];
        if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
          len_left_nxt     = (rx_byte[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
          payload_left_nxt = 64'd0;
          phase_nxt        = PH_EXTLEN;
        end else begin
          payload_left_nxt = {57'd0, rx_byte[6:0]};
          len_done         = 1'b1;
        end
      end
      PH_EXTLEN: begin
        payload_left_nxt = {payload_left_r[55:0], rx_byte};
        if (len_left_r == 3'd0) begin
          len_done = 1'b1;
        end else begin
          len_left_nxt = len_left_r - 3'd1;
        end
      end
      PH_MASK: begin
        mask_key_nxt   = {mask_key_r[2:0], rx_byte};
        mask_index_nxt = mask_index_r + 2'd1;
        hdr_done       = (mask_index_r == 2'd3);
      end
      PH_PAYLOAD: begin
        mask_index_nxt   = mask_index_r + 2'd1;
        payload_left_nxt = payload_left_r - 64'd1;
        if (op[3]) begin
          if (final_byte) begin
            phase_nxt = PH_HEAD0;
          end
          if (op != OP_PONG) begin
            has_res          = 1'b1;
            res.payload_byte = data_byte;
            res.kind         = KIND_CTRL;
            res.opcode       = op;
            res.reply        = !final_byte ? REPLY_NONE :
                               (op == OP_PING) ? REPLY_PONG : REPLY_ECHO;
            res.last         = final_byte;
            if (final_byte && op == OP_CLOSE) begin
              phase_nxt = PH_CLOSED;
            end
          end
        end else begin
          has_res          = 1'b1;
          res.payload_byte = data_byte;
          res.kind         = KIND_DATA;
          res.opcode       = message_opcode_r;
          res.last         = final_byte && fin;
          if (final_byte) begin
            fragment_open_nxt = ~fin;
            phase_nxt         = PH_HEAD0;
          end
        end
      end
      PH_CLOSED: begin
        phase_nxt = PH_CLOSED;
      end
      default: begin
        phase_nxt = PH_CLOSED;
      end
    endcase

    if (len_done) begin
      if ((|payload_left_nxt[63:32]) || (payload_left_nxt[31:0] > max_payload_r)) begin
        has_res        = 1'b1;
        res.kind       = KIND_ERR;
        res.opcode     = op;
        res.reply      = REPLY_CLOSE;
        res.error_code = ERR_OVERSIZE;
        phase_nxt      = PH_CLOSED;
      end else if (mask_present_nxt) begin
        mask_index_nxt = 2'd0;
        mask_key_nxt   = '0;
        phase_nxt      = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      if (op[3]) begin
        if (op != OP_CLOSE && op != OP_PING && op != OP_PONG) begin
          has_res        = 1'b1;
          res.kind       = KIND_ERR;
          res.opcode     = op;
          res.reply      = REPLY_CLOSE;
          res.error_code = ERR_CONTROL;
          phase_nxt      = PH_CLOSED;
        end else if (payload_left_nxt != 64'd0) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_HEAD0;
          if (op != OP_PONG) begin
            has_res    = 1'b1;
            res.kind   = KIND_EMPTY;
            res.opcode = op;
            res.reply  = (op == OP_PING) ? REPLY_PONG : REPLY_ECHO;
            res.last   = 1'b1;
            if (op == OP_CLOSE) begin
              phase_nxt = PH_CLOSED;
            end
          end
        end
      end else if (fragment_open_r == (op != OP_CONT)) begin
        has_res        = 1'b1;
        res.kind       = KIND_ERR;
        res.opcode     = op;
        res.reply      = REPLY_CLOSE;
        res.error_code = ERR_FRAGMENT;
        phase_nxt      = PH_CLOSED;
      end else begin
        if (!fragment_open_r) begin
          message_opcode_nxt = op;
        end
        if (payload_left_nxt != 64'd0) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          has_res           = 1'b1;
          res.kind          = KIND_EMPTY;
          res.opcode        = message_opcode_nxt;
          res.last          = fin;
          fragment_open_nxt = ~fin;
          phase_nxt         = PH_HEAD0;
        end
      end
    end

    if (phase_r == PH_CLOSED) begin
      has_res = 1'b0;
    end
  end

  assign status.has_res = has_res;
  assign status.res     = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HEAD0;
      frame_head_r     <= 8'd0;
      mask_present_r   <= 1'b0;
      len_left_r       <= 3'd0;
      payload_left_r   <= 64'd0;
      mask_key_r       <= '0;
      mask_index_r     <= 2'd0;
      fragment_open_r  <= 1'b0;
      message_opcode_r <= 4'd0;
    end else if (fire) begin
      phase_r          <= phase_nxt;
      frame_head_r     <= frame_head_nxt;
      mask_present_r   <= mask_present_nxt;
      len_left_r       <= len_left_nxt;
      payload_left_r   <= payload_left_nxt;
      mask_key_r       <= mask_key_nxt;
      mask_index_r     <= mask_index_nxt;
      fragment_open_r  <= fragment_open_nxt;
      message_opcode_r <= message_opcode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_data;
    end
  end

  `WSFR_ASSERT_NEXT(a_closed_sticky, phase_r == PH_CLOSED, phase_r == PH_CLOSED,
                    "closed state was left before reset")
  `WSFR_ASSERT_SAME(a_closed_silent, phase_r == PH_CLOSED, !has_res,
                    "result produced while closed")
  `WSFR_ASSERT_SAME(a_bytes_in_payload,
                    has_res && (res.kind == KIND_DATA || res.kind == KIND_CTRL),
                    phase_r == PH_PAYLOAD, "payload item outside payload phase")
  `WSFR_ASSERT_NEXT(a_error_closes, fire && has_res && res.kind == KIND_ERR,
                    phase_r == PH_CLOSED, "error item did not close the receiver")
  `WSFR_ASSERT_NEXT(a_message_end, fire && has_res && res.kind == KIND_DATA && res.last,
                    !fragment_open_r, "message still open after its final item")

endmodule

`default_nettype wire

[rtl/core/wsfr_out_reg.sv]
// Result register of the frame receiver with its valid/stall handshake.
// Depends on wsfr_pkg for the result item type.
`default_nettype none

module wsfr_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire wsfr_pkg::wsfr_result_t res_in,
  input  wire logic                 out_stall,
  output logic                      free,
  output logic                      out_valid,
  output logic [7:0]                out_payload_byte,
  output logic [1:0]                out_kind,
  output logic [3:0]                out_opcode,
  output logic [1:0]                out_reply,
  output logic [1:0]                out_error_code,
  output logic                      out_last
);
  import wsfr_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  wsfr_result_t res_r;

  assign free          = !out_valid_r || !out_stall;
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = res_r.payload_byte;
  assign out_kind         = res_r.kind;
  assign out_opcode       = res_r.opcode;
  assign out_reply        = res_r.reply;
  assign out_error_code   = res_r.error_code;
  assign out_last         = res_r.last;

endmodule

`default_nettype wire

[rtl/core/websocket_frame_receiver.sv]
// Top level of the WebSocket frame receiver: input register, parser, result register.
// Depends on wsfr_pkg, wsfr_frame_fsm and wsfr_out_reg.
`default_nettype none

// Receives one byte of a WebSocket connection per item and sustains one item per
// clock unless out_stall holds a result: each byte is held in an input register and
// goes through the combinational parser logic into the result register. Header and
// mask key bytes produce no item but an error or empty-frame item where the header
// ends; an error or a close frame closes the receiver, ignoring every byte, until
// reset. The max_payload register is written through the cfg_ port, always ready.
module websocket_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_max_payload,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_payload_byte,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_opcode,
  output logic [1:0]       out_reply,
  output logic [1:0]       out_error_code,
  output logic             out_last
);
  import wsfr_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_adv;
  logic         in_take;
  logic         out_free;
  wsfr_status_t status;

  assign cfg_ready    = 1'b1;
  assign s1_adv       = s1_valid_r && (!status.has_res || out_free);
  assign in_stall     = s1_valid_r && !s1_adv;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  wsfr_frame_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_max_payload),
    .rx_byte  (s1_byte_r),
    .fire     (s1_adv),
    .status   (status)
  );

  wsfr_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (s1_adv && status.has_res),
    .res_in           (status.res),
    .out_stall        (out_stall),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_payload_byte (out_payload_byte),
    .out_kind         (out_kind),
    .out_opcode       (out_opcode),
    .out_reply        (out_reply),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
